// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the SPH pair kernel RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset
`define SPHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define SPHK_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPHK_ASSERT(lbl, prop, msg)
`define SPHK_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/sphk_pkg.sv =====
// Package for the SPH pair kernel: pipeline depths, register codes,
// reset values and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sphk_pkg;

  // pipeline depths of the iterative units
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  localparam int DIV_RW      = 51;   // divisor / remainder width
  localparam int DIV_QW      = 32;   // quotient bits

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DIMS = 2'd0;
  localparam logic [1:0] REG_H    = 2'd1;
  localparam logic [1:0] REG_N3   = 2'd2;
  localparam logic [1:0] REG_N2   = 2'd3;

  localparam logic [30:0] H_RESET    = 31'd65536;
  localparam logic [31:0] N3_RESET   = 32'd1335088;
  localparam logic [31:0] N2_RESET   = 32'd1907584;
  localparam logic [63:0] HSQ4_RESET = 64'h0000_0004_0000_0000;

  // configuration as seen by the datapath
  typedef struct packed {
    logic        planar;
    logic [30:0] h_eff;
    logic [31:0] norm;
    logic [63:0] hsq4;
  } cfg_t;

  // sideband carried alongside the square root
  typedef struct packed {
    logic        valid;
    logic        support;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [32:0] az;
    logic        sx;
    logic        sy;
    logic        sz;
  } sq_side_t;

  // sideband carried alongside the first divider bank
  typedef struct packed {
    logic valid;
    logic support;
    logic sx;
    logic sy;
    logic sz;
  } dv_side_t;

  // sideband carried alongside the final divider bank
  typedef struct packed {
    logic        valid;
    logic        support;
    logic [31:0] kern;
    logic        negx;
    logic        negy;
    logic        negz;
    logic        ovx;
    logic        ovy;
    logic        ovz;
  } fn_side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sphk_cfg.sv =====
// Configuration registers behind an APB-style port.
// Depends on sphk_pkg; drives the cfg_t struct used by the datapath.
`timescale 1ns / 1ps
`default_nettype none
module sphk_cfg import sphk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic        dims_r;
  logic [30:0] h_r;
  logic [31:0] n3_r;
  logic [31:0] n2_r;
  logic [63:0] hsq4_r;
  logic [63:0] hsq4_nxt;
  logic [30:0] h_eff;
  logic [61:0] hsq;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 1'b0;
      h_r    <= H_RESET;
      n3_r   <= N3_RESET;
      n2_r   <= N2_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_DIMS: dims_r <= pwdata[0];
        REG_H:    h_r    <= pwdata[30:0];
        REG_N3:   n3_r   <= pwdata;
        REG_N2:   n2_r   <= pwdata;
        default:  ;
      endcase
    end
  end

  // zero length acts as one raw unit; 4*h^2 kept registered
  assign h_eff    = (h_r == 31'd0) ? 31'd1 : h_r;
  assign hsq      = h_eff * h_eff;
  assign hsq4_nxt = {hsq, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsq4_r <= HSQ4_RESET;
    end else begin
      hsq4_r <= hsq4_nxt;
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_DIMS: prdata = {31'd0, dims_r};
      REG_H:    prdata = {1'b0, h_r};
      REG_N3:   prdata = n3_r;
      REG_N2:   prdata = n2_r;
      default:  prdata = 32'd0;
    endcase
  end

  assign cfg.planar = dims_r;
  assign cfg.h_eff  = h_eff;
  assign cfg.norm   = dims_r ? n2_r : n3_r;
  assign cfg.hsq4   = hsq4_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sphk_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on sphk_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none
module sphk_isqrt import sphk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] in_val,
  output logic      [31:0] out_root
);

  logic [33:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];
  logic [63:0] v_r    [SQRT_STAGES];

  logic [33:0] cur_rem  [SQRT_STAGES];
  logic [31:0] cur_root [SQRT_STAGES];
  logic [63:0] cur_v    [SQRT_STAGES];
  logic [33:0] nrem     [SQRT_STAGES];
  logic [31:0] nroot    [SQRT_STAGES];
  logic [63:0] nv       [SQRT_STAGES];
  logic [35:0] acc      [SQRT_STAGES];
  logic [35:0] trial    [SQRT_STAGES];

  // stage inputs
  always_comb begin
    cur_rem[0]  = 34'd0;
    cur_root[0] = 32'd0;
    cur_v[0]    = in_val;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      cur_rem[k]  = rem_r[k-1];
      cur_root[k] = root_r[k-1];
      cur_v[k]    = v_r[k-1];
    end
  end

  // one digit step: bring down two bits, try root*4+1
  always_comb begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      acc[k]   = {cur_rem[k], cur_v[k][63:62]};
      trial[k] = {2'b00, cur_root[k], 2'b01};
      nv[k]    = {cur_v[k][61:0], 2'b00};
      if (acc[k] >= trial[k]) begin
        nrem[k]  = 34'(acc[k] - trial[k]);
        nroot[k] = {cur_root[k][30:0], 1'b1};
      end else begin
        nrem[k]  = acc[k][33:0];
        nroot[k] = {cur_root[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        rem_r[k]  <= nrem[k];
        root_r[k] <= nroot[k];
        v_r[k]    <= nv[k];
      end
    end
  end

  assign out_root = root_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sphk_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Caller gives a starting remainder below the divisor. Depends on sphk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sphk_div import sphk_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_RW-1:0] in_div,
  input  wire logic [DIV_RW-1:0] in_rem,
  input  wire logic [DIV_QW-1:0] in_low,
  output logic      [DIV_QW-1:0] out_quo
);

  logic [DIV_RW-1:0] div_r [DIV_STAGES];
  logic [DIV_RW-1:0] rem_r [DIV_STAGES];
  logic [DIV_QW-1:0] low_r [DIV_STAGES];
  logic [DIV_QW-1:0] quo_r [DIV_STAGES];

  logic [DIV_RW-1:0] cur_div [DIV_STAGES];
  logic [DIV_RW-1:0] cur_rem [DIV_STAGES];
  logic [DIV_QW-1:0] cur_low [DIV_STAGES];
  logic [DIV_QW-1:0] cur_quo [DIV_STAGES];
  logic [DIV_RW:0]   acc     [DIV_STAGES];
  logic [DIV_RW-1:0] nrem    [DIV_STAGES];
  logic [DIV_QW-1:0] nquo    [DIV_STAGES];

  // stage inputs
  always_comb begin
    cur_div[0] = in_div;
    cur_rem[0] = in_rem;
    cur_low[0] = in_low;
    cur_quo[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      cur_div[k] = div_r[k-1];
      cur_rem[k] = rem_r[k-1];
      cur_low[k] = low_r[k-1];
      cur_quo[k] = quo_r[k-1];
    end
  end

  // shift in one dividend bit, subtract if it fits
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      acc[k] = {cur_rem[k], cur_low[k][DIV_QW-1]};
      if (acc[k] >= {1'b0, cur_div[k]}) begin
        nrem[k] = DIV_RW'(acc[k] - {1'b0, cur_div[k]});
        nquo[k] = {cur_quo[k][DIV_QW-2:0], 1'b1};
      end else begin
        nrem[k] = acc[k][DIV_RW-1:0];
        nquo[k] = {cur_quo[k][DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_r[k] <= cur_div[k];
        rem_r[k] <= nrem[k];
        low_r[k] <= {cur_low[k][DIV_QW-2:0], 1'b0};
        quo_r[k] <= nquo[k];
      end
    end
  end

  assign out_quo = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/sph_pair_kernel_and_gradient_top.sv =====
// SPH pair kernel and gradient: top level, pipeline control and datapath.
// Depends on sphk_pkg, sphk_cfg, sphk_isqrt, sphk_div and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one particle pair per item:
//   two positions, signed Q16.16. Output channel (out_valid / out_stall)
//   returns one item per pair: cubic spline kernel, gradient x/y/z and
//   the in_support flag. Registers sit behind the APB-style port. The user
//   must write them only while no item is in flight; the block itself does
//   not enforce this. Throughput: one item per cycle while out_stall does
//   not hold the pipeline. There are 105 register stages: the 32-stage
//   square root, the 32-stage divider bank for d and the ratios, the
//   32-stage divider bank for the gradient magnitudes, plus nine
//   arithmetic and register stages.
//   All stages move together: while out_valid is high and out_stall is
//   high, the whole pipeline holds and in_stall is raised; no item is lost
//   or repeated. Empty slots in the pipeline are not squeezed out.
//   Reset clears all valid bits and loads the register defaults
//   (3D mode, h = 1.0, default norms).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sph_pair_kernel_and_gradient_top import sphk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pos_i_x,
  input  wire logic [31:0] in_pos_i_y,
  input  wire logic [31:0] in_pos_i_z,
  input  wire logic [31:0] in_pos_j_x,
  input  wire logic [31:0] in_pos_j_y,
  input  wire logic [31:0] in_pos_j_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_kernel_value,
  output logic      [31:0] out_grad_x,
  output logic      [31:0] out_grad_y,
  output logic      [31:0] out_grad_z,
  output logic             out_in_support,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  logic en;

  sphk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // global advance: hold everything while the output item is refused
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- stage A: differences ----------------
  logic        a_vld_r;
  logic [32:0] a_dx_r, a_dy_r, a_dz_r;
  logic [32:0] a_dx_nxt, a_dy_nxt, a_dz_nxt;

  assign a_dx_nxt = {in_pos_i_x[31], in_pos_i_x} - {in_pos_j_x[31], in_pos_j_x};
  assign a_dy_nxt = {in_pos_i_y[31], in_pos_i_y} - {in_pos_j_y[31], in_pos_j_y};
  assign a_dz_nxt = cfg.planar ? 33'd0 :
                    ({in_pos_i_z[31], in_pos_i_z} - {in_pos_j_z[31], in_pos_j_z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r <= a_dx_nxt;
      a_dy_r <= a_dy_nxt;
      a_dz_r <= a_dz_nxt;
    end
  end

  // ---------------- stage B: magnitudes and squares ----------------
  logic        b_vld_r;
  logic [32:0] b_ax_r, b_ay_r, b_az_r;
  logic        b_sx_r, b_sy_r, b_sz_r;
  logic [64:0] b_qx_r, b_qy_r, b_qz_r;
  logic [32:0] ax, ay, az;
  logic [65:0] qx, qy, qz;

  assign ax = a_dx_r[32] ? (~a_dx_r + 33'd1) : a_dx_r;
  assign ay = a_dy_r[32] ? (~a_dy_r + 33'd1) : a_dy_r;
  assign az = a_dz_r[32] ? (~a_dz_r + 33'd1) : a_dz_r;
  assign qx = ax * ax;
  assign qy = ay * ay;
  assign qz = az * az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ax_r <= ax;
      b_ay_r <= ay;
      b_az_r <= az;
      b_sx_r <= a_dx_r[32];
      b_sy_r <= a_dy_r[32];
      b_sz_r <= a_dz_r[32];
      b_qx_r <= qx[64:0];
      b_qy_r <= qy[64:0];
      b_qz_r <= qz[64:0];
    end
  end

  // ---------------- stage C: squared distance, support ----------------
  logic [65:0] sum66;
  logic        c_support;
  logic [63:0] c_sum_r;
  sq_side_t    c_side_r;
  sq_side_t    c_side_nxt;

  assign sum66     = {1'b0, b_qx_r} + {1'b0, b_qy_r} + {1'b0, b_qz_r};
  assign c_support = sum66 < {2'b00, cfg.hsq4};

  always_comb begin
    c_side_nxt.valid   = b_vld_r;
    c_side_nxt.support = c_support;
    c_side_nxt.ax      = b_ax_r;
    c_side_nxt.ay      = b_ay_r;
    c_side_nxt.az      = b_az_r;
    c_side_nxt.sx      = b_sx_r;
    c_side_nxt.sy      = b_sy_r;
    c_side_nxt.sz      = b_sz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_side_r <= '0;
    end else if (en) begin
      c_side_r <= c_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum_r <= c_support ? sum66[63:0] : 64'd0;
    end
  end

  // ---------------- square root ----------------
  logic [31:0] dist_q;
  sq_side_t    sq_dly_r [SQRT_STAGES];
  sq_side_t    sq_out;

  sphk_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .in_val   (c_sum_r),
    .out_root (dist_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) sq_dly_r[k] <= '0;
    end else if (en) begin
      sq_dly_r[0] <= c_side_r;
      for (int k = 1; k < SQRT_STAGES; k++) sq_dly_r[k] <= sq_dly_r[k-1];
    end
  end

  assign sq_out = sq_dly_r[SQRT_STAGES-1];

  // ---------------- divider bank: d and direction ratios ----------------
  logic [31:0]       dist_dvs;
  logic [32:0]       mx, my, mz;
  logic [DIV_QW-1:0] dq_quo, rx_quo, ry_quo, rz_quo;
  dv_side_t          dv_in;
  dv_side_t          dv_dly_r [DIV_STAGES];
  dv_side_t          dv_out;

  assign dist_dvs = (dist_q == 32'd0) ? 32'd1 : dist_q;
  assign mx = sq_out.support ? sq_out.ax : 33'd0;
  assign my = sq_out.support ? sq_out.ay : 33'd0;
  assign mz = sq_out.support ? sq_out.az : 33'd0;

  // d = distance * 2^30 / h
  sphk_div u_div_d (
    .clk     (clk),
    .en      (en),
    .in_div  ({20'd0, cfg.h_eff}),
    .in_rem  ({21'd0, dist_q[31:2]}),
    .in_low  ({dist_q[1:0], 30'd0}),
    .out_quo (dq_quo)
  );

  // ratio = |r_c| * 2^30 / distance
  sphk_div u_div_rx (
    .clk     (clk),
    .en      (en),
    .in_div  ({19'd0, dist_dvs}),
    .in_rem  ({20'd0, mx[32:2]}),
    .in_low  ({mx[1:0], 30'd0}),
    .out_quo (rx_quo)
  );

  sphk_div u_div_ry (
    .clk     (clk),
    .en      (en),
    .in_div  ({19'd0, dist_dvs}),
    .in_rem  ({20'd0, my[32:2]}),
    .in_low  ({my[1:0], 30'd0}),
    .out_quo (ry_quo)
  );

  sphk_div u_div_rz (
    .clk     (clk),
    .en      (en),
    .in_div  ({19'd0, dist_dvs}),
    .in_rem  ({20'd0, mz[32:2]}),
    .in_low  ({mz[1:0], 30'd0}),
    .out_quo (rz_quo)
  );

  always_comb begin
    dv_in.valid   = sq_out.valid;
    dv_in.support = sq_out.support;
    dv_in.sx      = sq_out.sx;
    dv_in.sy      = sq_out.sy;
    dv_in.sz      = sq_out.sz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) dv_dly_r[k] <= '0;
    end else if (en) begin
      dv_dly_r[0] <= dv_in;
      for (int k = 1; k < DIV_STAGES; k++) dv_dly_r[k] <= dv_dly_r[k-1];
    end
  end

  assign dv_out = dv_dly_r[DIV_STAGES-1];

  // ---------------- P1: t1, t2 ----------------
  logic [30:0] dq;
  dv_side_t    p1_side_r, p2_side_r, p3_side_r, p4_side_r, p5_side_r;
  logic [31:0] p1_t2_r;
  logic [30:0] p1_t1_r;
  logic [30:0] p1_rx_r, p1_ry_r, p1_rz_r;
  logic [31:0] t2_nxt;
  logic [30:0] t1_nxt;

  assign dq     = dq_quo[31] ? 31'h7FFF_FFFF : dq_quo[30:0];
  assign t2_nxt = 32'h8000_0000 - {1'b0, dq};
  assign t1_nxt = dq[30] ? 31'd0 : (31'h4000_0000 - dq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_side_r <= '0;
      p2_side_r <= '0;
      p3_side_r <= '0;
      p4_side_r <= '0;
      p5_side_r <= '0;
    end else if (en) begin
      p1_side_r <= dv_out;
      p2_side_r <= p1_side_r;
      p3_side_r <= p2_side_r;
      p4_side_r <= p3_side_r;
      p5_side_r <= p4_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_t2_r <= t2_nxt;
      p1_t1_r <= t1_nxt;
      p1_rx_r <= rx_quo[30:0];
      p1_ry_r <= ry_quo[30:0];
      p1_rz_r <= rz_quo[30:0];
    end
  end

  // ---------------- P2: squares ----------------
  logic [63:0] t2sq;
  logic [61:0] t1sq;
  logic [32:0] p2_t2s_r;
  logic [30:0] p2_t1s_r;
  logic [31:0] p2_t2_r;
  logic [30:0] p2_t1_r;
  logic [30:0] p2_rx_r, p2_ry_r, p2_rz_r;

  assign t2sq = p1_t2_r * p1_t2_r;
  assign t1sq = p1_t1_r * p1_t1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_t2s_r <= t2sq[62:30];
      p2_t1s_r <= t1sq[60:30];
      p2_t2_r  <= p1_t2_r;
      p2_t1_r  <= p1_t1_r;
      p2_rx_r  <= p1_rx_r;
      p2_ry_r  <= p1_ry_r;
      p2_rz_r  <= p1_rz_r;
    end
  end

  // ---------------- P3: cubes and gradient polynomial ----------------
  logic [64:0] t2cu;
  logic [61:0] t1cu;
  logic [33:0] q12, q3;
  logic [33:0] qdiff;
  logic        qneg;
  logic [33:0] p3_t2c_r;
  logic [30:0] p3_t1c_r;
  logic [31:0] p3_qmag_r;
  logic        p3_qneg_r;
  logic [30:0] p3_rx_r, p3_ry_r, p3_rz_r;

  assign t2cu  = p2_t2s_r * p2_t2_r;
  assign t1cu  = p2_t1s_r * p2_t1_r;
  assign q12   = 34'(p2_t1s_r) * 34'd12;
  assign q3    = 34'(p2_t2s_r) * 34'd3;
  assign qneg  = q3 > q12;
  assign qdiff = qneg ? (q3 - q12) : (q12 - q3);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_t2c_r  <= t2cu[63:30];
      p3_t1c_r  <= t1cu[60:30];
      p3_qmag_r <= qdiff[33:2];
      p3_qneg_r <= qneg;
      p3_rx_r   <= p2_rx_r;
      p3_ry_r   <= p2_ry_r;
      p3_rz_r   <= p2_rz_r;
    end
  end

  // ---------------- P4: kernel polynomial, norm times q ----------------
  logic [33:0] four_t1c;
  logic [63:0] nq;
  logic [33:0] p4_p30_r;
  logic [33:0] p4_a_r;
  logic        p4_qneg_r;
  logic [30:0] p4_rx_r, p4_ry_r, p4_rz_r;

  assign four_t1c = {1'b0, p3_t1c_r, 2'b00};
  assign nq       = cfg.norm * p3_qmag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_p30_r  <= (p3_t2c_r > four_t1c) ? (p3_t2c_r - four_t1c) : 34'd0;
      p4_a_r    <= nq[63:30];
      p4_qneg_r <= p3_qneg_r;
      p4_rx_r   <= p3_rx_r;
      p4_ry_r   <= p3_ry_r;
      p4_rz_r   <= p3_rz_r;
    end
  end

  // ---------------- P5: kernel value, a times ratio ----------------
  logic [63:0] kprod;
  logic [64:0] bx, by, bz;
  logic [31:0] p5_kern_r;
  logic [63:0] p5_bx_r, p5_by_r, p5_bz_r;
  logic        p5_qneg_r;

  assign kprod = cfg.norm * p4_p30_r[33:2];
  assign bx    = p4_a_r * p4_rx_r;
  assign by    = p4_a_r * p4_ry_r;
  assign bz    = p4_a_r * p4_rz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_kern_r <= {4'd0, kprod[63:36]};
      p5_bx_r   <= bx[63:0];
      p5_by_r   <= by[63:0];
      p5_bz_r   <= bz[63:0];
      p5_qneg_r <= p4_qneg_r;
    end
  end

  // ---------------- final divider bank: b / (h * 2^20) ----------------
  logic [DIV_RW-1:0] hdiv;
  logic [DIV_RW-1:0] hx, hy, hz;
  logic              ovx, ovy, ovz;
  logic [DIV_QW-1:0] gx_quo, gy_quo, gz_quo;
  fn_side_t          fn_in;
  fn_side_t          fn_dly_r [DIV_STAGES];
  fn_side_t          fn_out;

  assign hdiv = {cfg.h_eff, 20'd0};
  assign hx   = {19'd0, p5_bx_r[63:32]};
  assign hy   = {19'd0, p5_by_r[63:32]};
  assign hz   = {19'd0, p5_bz_r[63:32]};
  // quotient of 2^32 or more saturates regardless
  assign ovx  = hx >= hdiv;
  assign ovy  = hy >= hdiv;
  assign ovz  = hz >= hdiv;

  sphk_div u_div_gx (
    .clk     (clk),
    .en      (en),
    .in_div  (hdiv),
    .in_rem  (ovx ? '0 : hx),
    .in_low  (p5_bx_r[31:0]),
    .out_quo (gx_quo)
  );

  sphk_div u_div_gy (
    .clk     (clk),
    .en      (en),
    .in_div  (hdiv),
    .in_rem  (ovy ? '0 : hy),
    .in_low  (p5_by_r[31:0]),
    .out_quo (gy_quo)
  );

  sphk_div u_div_gz (
    .clk     (clk),
    .en      (en),
    .in_div  (hdiv),
    .in_rem  (ovz ? '0 : hz),
    .in_low  (p5_bz_r[31:0]),
    .out_quo (gz_quo)
  );

  always_comb begin
    fn_in.valid   = p5_side_r.valid;
    fn_in.support = p5_side_r.support;
    fn_in.kern    = p5_kern_r;
    fn_in.negx    = p5_side_r.sx ^ p5_qneg_r;
    fn_in.negy    = p5_side_r.sy ^ p5_qneg_r;
    fn_in.negz    = p5_side_r.sz ^ p5_qneg_r;
    fn_in.ovx     = ovx;
    fn_in.ovy     = ovy;
    fn_in.ovz     = ovz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) fn_dly_r[k] <= '0;
    end else if (en) begin
      fn_dly_r[0] <= fn_in;
      for (int k = 1; k < DIV_STAGES; k++) fn_dly_r[k] <= fn_dly_r[k-1];
    end
  end

  assign fn_out = fn_dly_r[DIV_STAGES-1];

  // ---------------- output stage: sign and saturation ----------------
  function automatic logic [31:0] sat_grad(input logic [31:0] mag, input logic ov,
                                           input logic neg);
    logic [31:0] m;
    begin
      if (neg) begin
        m = (ov || mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
        sat_grad = ~m + 32'd1;
      end else begin
        sat_grad = (ov || mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
      end
    end
  endfunction

  logic [31:0] out_kernel_r, out_gx_r, out_gy_r, out_gz_r;
  logic        out_sup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fn_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sup_r    <= fn_out.support;
      out_kernel_r <= fn_out.support ? fn_out.kern : 32'd0;
      out_gx_r     <= fn_out.support ? sat_grad(gx_quo, fn_out.ovx, fn_out.negx) : 32'd0;
      out_gy_r     <= fn_out.support ? sat_grad(gy_quo, fn_out.ovy, fn_out.negy) : 32'd0;
      out_gz_r     <= fn_out.support ? sat_grad(gz_quo, fn_out.ovz, fn_out.negz) : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kernel_value = out_kernel_r;
  assign out_grad_x       = out_gx_r;
  assign out_grad_y       = out_gy_r;
  assign out_grad_z       = out_gz_r;
  assign out_in_support   = out_sup_r;

  // ---------------- checks ----------------
  `SPHK_ASSERT(a_outside_zero, out_valid_r && !out_sup_r |-> out_kernel_r == 32'd0 && out_gx_r == 32'd0 && out_gy_r == 32'd0 && out_gz_r == 32'd0, "result outside support not zero")
  `SPHK_ASSERT(a_kernel_range, out_valid_r |-> out_kernel_r[31:27] == 5'd0, "kernel value above its bound")
  `SPHK_ASSERT(a_planar_z, out_valid_r && cfg.planar |-> out_gz_r == 32'd0, "planar item with z gradient")
  `SPHK_ASSERT_NR(a_reset_quiet, !rst_n |=> !out_valid_r, "output valid right after reset")

endmodule
`default_nettype wire
